// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEMORY = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] REG_POOL_SIZE  = 2'd0;
    localparam logic [1:0] REG_HEADER_LEN = 2'd1;
    localparam logic [1:0] REG_ALIGN_LOG2 = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_size;
        logic [15:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_offset;
        logic [16:0] used_bytes;
    } rsp_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        ins;       // shift right from slot sel, write new entry at sel
        logic        rem;       // shift left from slot sel
        logic [15:0] new_start;
        logic [15:0] new_payload;
        logic [6:0]  header_len;
        logic [1:0]  align_log2;
        logic [15:0] free_offset;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell
// One table slot: holds a block, checks the gap behind it, matches a free.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire ffba_pkg::cell_ctl_t ctl,
    input  wire                  sel_here,    // this slot is the edit point
    input  wire                  after_sel,   // this slot lies beyond the edit point
    input  wire                  live,        // slot index below block count
    input  wire                  next_live,   // right neighbor holds a block
    input  wire [15:0]           prev_start,  // left neighbor contents
    input  wire [15:0]           prev_payload,
    input  wire [15:0]           next_start,  // right neighbor contents
    input  wire [15:0]           next_payload,
    input  wire [16:0]           pool_end,
    input  wire [16:0]           need,
    output logic [15:0]          start,
    output logic [15:0]          payload,
    output logic                 fit_reg,     // gap after this block fits
    output logic                 match_reg    // data offset equals the free
);
    logic [15:0] start_reg, start_next;
    logic [15:0] payload_reg, payload_next;
    logic [17:0] lo, hi, mask;
    logic [17:0] endb;

    assign start   = start_reg;
    assign payload = payload_reg;

    always_comb
    begin
        mask = (18'd1 << ctl.align_log2) - 18'd1;
        endb = {2'b0, start_reg} + {11'b0, ctl.header_len} + {2'b0, payload_reg};
        lo   = (endb + mask) & ~mask;
        hi   = next_live ? {2'b0, next_start} : {1'b0, pool_end};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            fit_reg   <= live && (lo + {1'b0, need} <= hi)
                         && (lo + {11'b0, ctl.header_len} <= 18'hFFFF);
            match_reg <= live && ({1'b0, start_reg} + {10'b0, ctl.header_len}
                         == {1'b0, ctl.free_offset});
        end
    end

    always_comb
    begin
        start_next   = start_reg;
        payload_next = payload_reg;
        if (ctl.ins && sel_here)
        begin
            start_next   = ctl.new_start;
            payload_next = ctl.new_payload;
        end
        else if (ctl.ins && after_sel)
        begin
            start_next   = prev_start;
            payload_next = prev_payload;
        end
        else if (ctl.rem && (sel_here || after_sel))
        begin
            start_next   = next_start;
            payload_next = next_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        payload_reg <= payload_next;
    end
endmodule
`default_nettype wire

// ----- rtl/ffba_pick.sv -----
// ----------------------------------------------------------------------------
// ffba_pick
// Priority pick of the lowest set flag, as a registered two-level search.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_pick #(
    parameter int N  = 64,
    parameter int IW = 6
) (
    input  wire           clk,
    input  wire [N-1:0]   flags,
    output logic          any_reg,
    output logic [IW-1:0] idx_reg
);
    localparam int G  = 8;
    localparam int NG = (N + G - 1) / G;

    logic [NG-1:0] grp_any_reg;
    logic [2:0]    grp_idx_reg [NG];

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_reg[g] <= 1'b0;
            grp_idx_reg[g] <= 3'd0;
            for (int b = G - 1; b >= 0; b--)
            begin
                if (g * G + b < N && flags[g * G + b])
                begin
                    grp_any_reg[g] <= 1'b1;
                    grp_idx_reg[g] <= 3'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        any_reg <= |grp_any_reg;
        idx_reg <= '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
                idx_reg <= IW'(g * G + int'(grp_idx_reg[g]));
        end
    end
endmodule
`default_nettype wire

// ----- rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over one pool, with the block table held in a row of cells.
// ----------------------------------------------------------------------------
// Sequence: the cells check their gaps (S_CHECK), a two-level registered pick
// follows (S_PICK1, S_PICK2), then the table shifts (S_EDIT) and done is
// registered from S_EDIT. A new command is taken only in idle, at the same edge
// at which the result under done is taken.
// Reset: table empty, used count zero, registers at their reset values.
// The receiver cannot stall; each result shows for one cycle under done.
`default_nettype none
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int POOL_BYTES = 65536
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire ffba_pkg::req_t   req,
    output logic                  done,
    output ffba_pkg::rsp_t        rsp,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [1:0]             cfg_index,
    input  wire [16:0]            cfg_data
);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [16:0] POOL_CAP = (POOL_BYTES > 65536) ? 17'd65536 : 17'(POOL_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PICK1 = 3'd2;
    localparam logic [2:0] S_PICK2 = 3'd3;
    localparam logic [2:0] S_EDIT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [16:0] pool_size_reg;
    logic [6:0]  header_len_reg;
    logic [1:0]  align_log2_reg;
    logic [CW-1:0] count_reg;
    logic [16:0] used_reg;
    ffba_pkg::req_t req_reg;
    ffba_pkg::rsp_t rsp_reg;
    logic        done_reg;

    logic [16:0] pool_end, need;
    logic        too_big, full;
    ffba_pkg::cell_ctl_t ctl;
    logic [IW-1:0] sel_idx;

    logic [15:0] c_start   [MAX_BLOCKS];
    logic [15:0] c_payload [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] c_fit, c_match;
    logic [MAX_BLOCKS:0]   flags;
    logic        pick_any;
    logic [IW:0] pick_idx;
    logic        head_fit_reg;
    logic [15:0] first_start;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // Command and config capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg  <= 17'd65536;
            header_len_reg <= 7'd16;
            align_log2_reg <= 2'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ffba_pkg::REG_POOL_SIZE:  pool_size_reg  <= cfg_data;
                ffba_pkg::REG_HEADER_LEN: header_len_reg <= cfg_data[6:0];
                ffba_pkg::REG_ALIGN_LOG2: align_log2_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
    end

    always_comb
    begin
        pool_end = (pool_size_reg > POOL_CAP) ? POOL_CAP : pool_size_reg;
        need     = {10'b0, header_len_reg} + {1'b0, req_reg.request_size};
        too_big  = need > pool_end;
        full     = count_reg >= CW'(MAX_BLOCKS);
    end

    // Gap before the first block, offset 0
    assign first_start = c_start[0];
    always_ff @(posedge clk)
    begin
        head_fit_reg <= (need <= ((count_reg != '0) ? {1'b0, first_start} : pool_end))
                        && ({10'b0, header_len_reg} <= 17'hFFFF);
    end

    // Flag 0 is the head gap; flag k+1 is the gap after block k.
    // For a free, flag k is the match of block k.
    always_comb
    begin
        if (req_reg.operation == ffba_pkg::OP_FREE)
            flags = {1'b0, c_match};
        else
            flags = {c_fit, head_fit_reg};
    end

    ffba_pick #(.N(MAX_BLOCKS + 1), .IW(IW + 1)) u_pick (
        .clk     (clk),
        .flags   (flags),
        .any_reg (pick_any),
        .idx_reg (pick_idx)
    );

    always_comb
    begin
        sel_idx  = pick_idx[IW-1:0];
        ctl.header_len  = header_len_reg;
        ctl.align_log2  = align_log2_reg;
        ctl.free_offset = req_reg.free_offset;
        ctl.new_payload = req_reg.request_size;
        if (pick_idx == '0)
            ctl.new_start = 16'd0;
        else
            ctl.new_start = 16'((({2'b0, c_start[pick_idx[IW-1:0] - IW'(1)]}
                + {11'b0, header_len_reg} + {2'b0, c_payload[pick_idx[IW-1:0] - IW'(1)]}
                + ((18'd1 << align_log2_reg) - 18'd1))
                & ~((18'd1 << align_log2_reg) - 18'd1)));
        ctl.ins = (state_reg == S_EDIT) && (req_reg.operation == ffba_pkg::OP_ALLOC)
                  && !too_big && !full && pick_any;
        ctl.rem = (state_reg == S_EDIT) && (req_reg.operation == ffba_pkg::OP_FREE)
                  && pick_any;
    end

    // Row of cells; each sees its neighbors
    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++)
        begin : g_cell
            localparam int PV = (gi == 0) ? 0 : gi - 1;
            localparam int NX = (gi == MAX_BLOCKS - 1) ? gi : gi + 1;
            ffba_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .sel_here     (sel_idx == IW'(gi)),
                .after_sel    (IW'(gi) > sel_idx),
                .live         (CW'(gi) < count_reg),
                .next_live    ((gi < MAX_BLOCKS - 1) && (CW'(gi + 1) < count_reg)),
                .prev_start   (c_start[PV]),
                .prev_payload (c_payload[PV]),
                .next_start   (c_start[NX]),
                .next_payload (c_payload[NX]),
                .pool_end     (pool_end),
                .need         (need),
                .start        (c_start[gi]),
                .payload      (c_payload[gi]),
                .fit_reg      (c_fit[gi]),
                .match_reg    (c_match[gi])
            );
        end
    endgenerate

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_CHECK;
            S_CHECK: state_next = S_PICK1;
            S_PICK1: state_next = S_PICK2;
            S_PICK2: state_next = S_EDIT;
            S_EDIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EDIT);
            if (ctl.ins)
            begin
                count_reg <= count_reg + CW'(1);
                used_reg  <= ({1'b0, used_reg} + {1'b0, need} > 18'h1FFFF) ? 17'h1FFFF
                             : used_reg + need;
            end
            else if (ctl.rem)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (ctl.rem)
                used_reg <= (used_reg >= ({10'b0, header_len_reg}
                             + {1'b0, c_payload[sel_idx]}))
                            ? used_reg - ({10'b0, header_len_reg} + {1'b0, c_payload[sel_idx]})
                            : 17'd0;
        end
    end

    // Result register: drop the status, offset and used count for this command
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EDIT)
        begin
            rsp_reg.used_bytes <= used_reg;
            rsp_reg.data_offset <= 16'd0;
            if (req_reg.operation == ffba_pkg::OP_FREE)
            begin
                rsp_reg.status <= pick_any ? ffba_pkg::ST_OK : ffba_pkg::ST_NOT_FOUND;
                if (pick_any)
                    rsp_reg.used_bytes <= (used_reg >= ({10'b0, header_len_reg}
                        + {1'b0, c_payload[sel_idx]}))
                        ? used_reg - ({10'b0, header_len_reg} + {1'b0, c_payload[sel_idx]})
                        : 17'd0;
            end
            else if (too_big)
                rsp_reg.status <= ffba_pkg::ST_NO_MEMORY;
            else if (full)
                rsp_reg.status <= ffba_pkg::ST_FULL;
            else if (!pick_any)
                rsp_reg.status <= ffba_pkg::ST_NO_MEMORY;
            else
            begin
                rsp_reg.status <= ffba_pkg::ST_OK;
                rsp_reg.data_offset <= ctl.new_start + {9'b0, header_len_reg};
                rsp_reg.used_bytes <= ({1'b0, used_reg} + {1'b0, need} > 18'h1FFFF)
                    ? 17'h1FFFF : used_reg + need;
            end
        end
    end

    // Checks
    a_done_after_edit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_EDIT)
        else $error("result strobe without an edit cycle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("block count above table depth");
    a_one_edit: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins && ctl.rem))
        else $error("insert and remove in one cycle");
    a_count_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("count changed while idle");
endmodule
`default_nettype wire
